// ===== hdl/programmable_sound_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the programmable sound generator
// Concurrent checks on clk_i, disabled while rst_ni is low. They compile
// away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_SOUND_GENERATOR_CORE_MACROS_SVH
`define PROGRAMMABLE_SOUND_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold on every edge outside reset
`define PSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psg assertion failed");
// Implication checked on every edge outside reset
`define PSG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psg implication failed");
`else
`define PSG_ASSERT(lbl, prop)
`define PSG_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== hdl/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the attenuation table of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_MIX   = 2'd2,
    OP_CHAN  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 1'd1;

  localparam int unsigned NUM_CH = 4;
  localparam int unsigned NUM_TONE = 3;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned NCOUNT_W = 16;
  localparam logic [1:0] NOISE_CH = 2'd3;
  localparam logic [15:0] NOISE_SEED = 16'h8000;

  // Noise channel control from the byte decoder
  typedef struct packed {
    logic       tick;
    logic       ctrl_write;
    logic [1:0] rate;
    logic       white;
  } noise_ctrl_t;

  // Attenuation table: amplitude per 4-bit volume code (15 is silent)
  function automatic logic [13:0] vol_amp(input logic [3:0] vol);
    logic [13:0] amp;
    case (vol)
      4'd0:    amp = 14'd8191;
      4'd1:    amp = 14'd6507;
      4'd2:    amp = 14'd5168;
      4'd3:    amp = 14'd4105;
      4'd4:    amp = 14'd3261;
      4'd5:    amp = 14'd2590;
      4'd6:    amp = 14'd2057;
      4'd7:    amp = 14'd1642;
      4'd8:    amp = 14'd1298;
      4'd9:    amp = 14'd1031;
      4'd10:   amp = 14'd819;
      4'd11:   amp = 14'd650;
      4'd12:   amp = 14'd516;
      4'd13:   amp = 14'd410;
      4'd14:   amp = 14'd326;
      default: amp = 14'd0;
    endcase
    return amp;
  endfunction

  // Signed channel output: +amp for high polarity, -amp for low
  function automatic logic signed [15:0] chan_value(input logic [3:0] vol,
                                                   input logic pol);
    logic signed [15:0] amp;
    amp = signed'({2'b00, vol_amp(vol)});
    return pol ? amp : -amp;
  endfunction

endpackage

// ===== hdl/psg_noise.sv =====
// ----------------------------------------------------------------------------
// psg_noise
// Noise voice: rate counter, phase divider and 16-bit shift register.
// ----------------------------------------------------------------------------
module psg_noise (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psg_pkg::noise_ctrl_t ctrl_i,
  input  logic [9:0]          tone2_period_i,
  output logic                polarity_o
);
  import psg_pkg::*;

  logic [NCOUNT_W-1:0] count_q, count_d;
  logic                phase_q, phase_d;
  logic [15:0]         shifter_q, shifter_d;
  logic [1:0]          rate_q, rate_d;
  logic                white_q, white_d;
  logic                pol_q, pol_d;
  logic [NCOUNT_W-1:0] reload;
  logic [NCOUNT_W-1:0] sum;
  logic                fb;

  // Reload value for the selected rate
  always_comb begin
    case (rate_q)
      2'd0:    reload = NCOUNT_W'(16);
      2'd1:    reload = NCOUNT_W'(32);
      2'd2:    reload = NCOUNT_W'(64);
      default: reload = {2'b00, tone2_period_i, 4'b0000};
    endcase
  end

  assign sum = count_q + reload;
  assign fb  = white_q ? (shifter_q[0] ^ shifter_q[3]) : shifter_q[0];

  // Counter, phase and shifter update
  always_comb begin
    count_d   = count_q;
    phase_d   = phase_q;
    shifter_d = shifter_q;
    rate_d    = rate_q;
    white_d   = white_q;
    pol_d     = pol_q;
    if (ctrl_i.ctrl_write) begin
      rate_d    = ctrl_i.rate;
      white_d   = ctrl_i.white;
      shifter_d = NOISE_SEED;
    end else if (ctrl_i.tick) begin
      if (count_q > NCOUNT_W'(1)) begin
        count_d = count_q - NCOUNT_W'(1);
      end else begin
        // expiry: zero reload holds the counter at zero
        count_d = (sum != '0) ? sum - NCOUNT_W'(1) : '0;
        phase_d = ~phase_q;
        if (!phase_q) begin
          pol_d     = shifter_q[0];
          shifter_d = {fb, shifter_q[15:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      phase_q   <= 1'b0;
      shifter_q <= NOISE_SEED;
      rate_q    <= 2'd0;
      white_q   <= 1'b0;
      pol_q     <= 1'b1;
    end else begin
      count_q   <= count_d;
      phase_q   <= phase_d;
      shifter_q <= shifter_d;
      rate_q    <= rate_d;
      white_q   <= white_d;
      pol_q     <= pol_d;
    end
  end

  assign polarity_o = pol_q;

endmodule

// ===== hdl/programmable_sound_generator_core.sv =====
// ----------------------------------------------------------------------------
// programmable_sound_generator_core
// Four-voice sound generator: three square tones and one noise voice.
// ----------------------------------------------------------------------------
// Items pass through an input register and are executed from it against the
// voice state, so one item is taken every cycle unless a sample request waits
// on a full, stalled output register. A sample request passes the input
// register, then the output register, and waits there while out_stall_i is
// high; writes and ticks give no output. Throughput is one item per cycle,
// set by the single execute stage that updates the state and the output register together.
module programmable_sound_generator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [1:0]                         channel_i,
  input  logic                               debug_view_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [15:0]                 sample_o
);
  import psg_pkg::*;

`include "programmable_sound_generator_core_macros.svh"

  // Configuration registers
  logic       master_en_q;
  logic [3:0] chan_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_en_q <= 1'b1;
      chan_en_q   <= 4'hF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MASTER_ENABLE:  master_en_q <= cfg_data_i[0];
        CFG_CHANNEL_ENABLE: chan_en_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register and handshake
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [7:0] s1_byte_q;
  logic [1:0] s1_chan_q;
  logic       s1_dbg_q;
  logic       s1_has_result;
  logic       s1_advance;
  logic       out_free;
  logic       in_xfer;
  logic       out_valid_q;
  logic signed [15:0] sample_q;

  assign s1_has_result = (s1_op_q == OP_MIX) || (s1_op_q == OP_CHAN);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign s1_advance    = s1_valid_q && (!s1_has_result || out_free);
  assign in_stall_o    = s1_valid_q && !s1_advance;
  assign in_xfer       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= op_e'(operation_i);
      s1_byte_q <= data_byte_i;
      s1_chan_q <= channel_i;
      s1_dbg_q  <= debug_view_i;
    end
  end

  // Voice state
  logic [3:0]          vol_q [NUM_CH];
  logic [3:0]          vol_d [NUM_CH];
  logic [PERIOD_W-1:0] period_q [NUM_TONE];
  logic [PERIOD_W-1:0] period_d [NUM_TONE];
  logic [PERIOD_W-1:0] count_q [NUM_TONE];
  logic [PERIOD_W-1:0] count_d [NUM_TONE];
  logic [NUM_TONE-1:0] tpol_q, tpol_d;
  logic [1:0]          lat_tgt_q, lat_tgt_d;
  logic                lat_vol_q, lat_vol_d;
  noise_ctrl_t         noise_ctrl;
  logic                noise_pol;

  logic       do_write;
  logic       do_tick;
  logic       is_latch;
  logic [1:0] tgt;
  logic       tgt_vol;
  logic [PERIOD_W-1:0] dec;

  assign do_write = s1_advance && (s1_op_q == OP_WRITE);
  assign do_tick  = s1_advance && (s1_op_q == OP_TICK);
  assign is_latch = s1_byte_q[7];
  assign tgt      = is_latch ? s1_byte_q[6:5] : lat_tgt_q;
  assign tgt_vol  = is_latch ? s1_byte_q[4] : lat_vol_q;

  // Byte decode and tone counters
  always_comb begin
    lat_tgt_d  = lat_tgt_q;
    lat_vol_d  = lat_vol_q;
    vol_d      = vol_q;
    period_d   = period_q;
    count_d    = count_q;
    tpol_d     = tpol_q;
    dec        = '0;
    noise_ctrl = '{tick: do_tick, ctrl_write: 1'b0,
                   rate: s1_byte_q[1:0], white: s1_byte_q[2]};
    if (do_write) begin
      if (is_latch) begin
        lat_tgt_d = s1_byte_q[6:5];
        lat_vol_d = s1_byte_q[4];
      end
      if (tgt_vol) begin
        vol_d[tgt] = s1_byte_q[3:0];
      end else if (tgt == NOISE_CH) begin
        noise_ctrl.ctrl_write = 1'b1;
      end else begin
        for (int i = 0; i < NUM_TONE; i++) begin
          if (tgt == 2'(i)) begin
            if (is_latch) begin
              period_d[i] = {period_q[i][9:4], s1_byte_q[3:0]};
            end else begin
              period_d[i] = {s1_byte_q[5:0], period_q[i][3:0]};
            end
          end
        end
      end
    end
    if (do_tick) begin
      for (int i = 0; i < NUM_TONE; i++) begin
        dec = (count_q[i] != '0) ? count_q[i] - PERIOD_W'(1) : '0;
        if (dec == '0) begin
          count_d[i] = period_q[i];
          tpol_d[i]  = ~tpol_q[i];
        end else begin
          count_d[i] = dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        vol_q[i] <= 4'hF;
      end
      for (int i = 0; i < NUM_TONE; i++) begin
        period_q[i] <= '0;
        count_q[i]  <= '0;
      end
      tpol_q    <= '1;
      lat_tgt_q <= 2'd0;
      lat_vol_q <= 1'b0;
    end else begin
      vol_q     <= vol_d;
      period_q  <= period_d;
      count_q   <= count_d;
      tpol_q    <= tpol_d;
      lat_tgt_q <= lat_tgt_d;
      lat_vol_q <= lat_vol_d;
    end
  end

  psg_noise u_noise (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (noise_ctrl),
    .tone2_period_i (period_q[2]),
    .polarity_o     (noise_pol)
  );

  // Sample computation
  logic [NUM_CH-1:0]  pol_all;
  logic signed [15:0] cval [NUM_CH];
  logic signed [15:0] mix_sum;
  logic signed [15:0] result;

  assign pol_all = {noise_pol, tpol_q};

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      cval[i] = chan_value(vol_q[i], pol_all[i]);
    end
    mix_sum = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (chan_en_q[i]) begin
        mix_sum = mix_sum + cval[i];
      end
    end
    if (s1_op_q == OP_CHAN) begin
      result = cval[s1_chan_q];
    end else if (master_en_q || s1_dbg_q) begin
      result = mix_sum;
    end else begin
      result = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && s1_has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_has_result) begin
      sample_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // Checks
  `PSG_ASSERT_IMPL(a_stall_needs_item, in_stall_o, s1_valid_q)
  `PSG_ASSERT_IMPL(a_out_from_request, $rose(out_valid_q), $past(s1_advance && s1_has_result))
  `PSG_ASSERT_IMPL(a_no_result_op, s1_advance && !s1_has_result, ##1 (out_valid_q == $past(out_valid_q && out_stall_i)))

endmodule

// ===== tb/psg_sample_checker.sv =====
// ----------------------------------------------------------------------------
// psg_sample_checker
// Watches the item, sample and register ports of the sound generator. It
// keeps its own copy of the voice state, works out every sample that an
// accepted request must return, and compares the samples in order.
// ----------------------------------------------------------------------------
module psg_sample_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [1:0]                         operation_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [1:0]                         channel_i,
  input  logic                               debug_view_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [15:0]                 sample_i,
  output int                                 errors_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  import psg_pkg::*;

  // Register copies
  logic       master_en;
  logic [3:0] voice_en;

  // Voice state
  logic [3:0]  pol;
  logic [3:0]  vol [4];
  logic [9:0]  period [3];
  logic [9:0]  tcount [3];
  logic [15:0] ncount;
  logic        nphase;
  logic [15:0] lfsr;
  logic [1:0]  nrate;
  logic        nwhite;
  logic [1:0]  lat_target;
  logic        lat_vol;

  // Samples owed by the block, oldest first
  logic signed [15:0] owed_samples [$];

  // Attenuation curve: amplitude per volume code, code 15 is silent
  function automatic int amplitude(input logic [3:0] code);
    int a;
    case (code)
      4'd0:    a = 8191;
      4'd1:    a = 6507;
      4'd2:    a = 5168;
      4'd3:    a = 4105;
      4'd4:    a = 3261;
      4'd5:    a = 2590;
      4'd6:    a = 2057;
      4'd7:    a = 1642;
      4'd8:    a = 1298;
      4'd9:    a = 1031;
      4'd10:   a = 819;
      4'd11:   a = 650;
      4'd12:   a = 516;
      4'd13:   a = 410;
      4'd14:   a = 326;
      default: a = 0;
    endcase
    return a;
  endfunction

  function automatic int voice_level(input int c);
    int a;
    a = amplitude(vol[c]);
    return pol[c] ? a : -a;
  endfunction

  function automatic int mixed_level(input logic dbg);
    int sum;
    sum = 0;
    if (!master_en && !dbg) return 0;
    for (int i = 0; i < 4; i++)
      if (voice_en[i]) sum += voice_level(i);
    return sum;
  endfunction

  // Latch/data byte protocol
  function automatic void chip_write(input logic [7:0] b);
    if (b[7]) begin
      lat_target = b[6:5];
      lat_vol    = b[4];
    end
    if (lat_vol) begin
      vol[lat_target] = b[3:0];
    end else if (lat_target == NOISE_CH) begin
      // noise control write always reseeds the shifter
      lfsr   = NOISE_SEED;
      nrate  = b[1:0];
      nwhite = b[2];
    end else if (b[7]) begin
      period[lat_target][3:0] = b[3:0];
    end else begin
      period[lat_target][9:4] = b[5:0];
    end
  endfunction

  // One chip clock: noise first, then the three tones
  function automatic void chip_tick();
    int  reload;
    int  nxt;
    logic fb;
    if (ncount > 16'd1) begin
      ncount = ncount - 16'd1;
    end else begin
      case (nrate)
        2'd0:    reload = 16;
        2'd1:    reload = 32;
        2'd2:    reload = 64;
        default: reload = int'(period[2]) * 16;
      endcase
      nxt = int'(ncount) + reload;
      // a zero reload holds the count at zero
      ncount = (nxt > 0) ? 16'(nxt - 1) : 16'd0;
      nphase = ~nphase;
      if (nphase) begin
        pol[3] = lfsr[0];
        fb     = nwhite ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
        lfsr   = {fb, lfsr[15:1]};
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (tcount[i] != 10'd0) tcount[i] = tcount[i] - 10'd1;
      if (tcount[i] == 10'd0) begin
        tcount[i] = period[i];
        pol[i]    = ~pol[i];
      end
    end
  endfunction

  function automatic void clear_state();
    master_en  = 1'b1;
    voice_en   = 4'hF;
    pol        = 4'hF;
    for (int i = 0; i < 4; i++) vol[i] = 4'hF;
    for (int i = 0; i < 3; i++) begin
      period[i] = '0;
      tcount[i] = '0;
    end
    ncount     = '0;
    nphase     = 1'b0;
    lfsr       = NOISE_SEED;
    nrate      = '0;
    nwhite     = 1'b0;
    lat_target = '0;
    lat_vol    = 1'b0;
    owed_samples.delete();
  endfunction

  function automatic void flag(input string what, input int want, input int got);
    if (errors_o < 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    errors_o++;
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  // Track register writes, item transfers and sample transfers
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MASTER_ENABLE) master_en = cfg_data_i[0];
        else if (cfg_index_i == CFG_CHANNEL_ENABLE) voice_en = cfg_data_i[3:0];
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_e'(operation_i))
          OP_WRITE: chip_write(data_byte_i);
          OP_TICK:  chip_tick();
          OP_MIX:   owed_samples.push_back(16'(mixed_level(debug_view_i)));
          default:  owed_samples.push_back(16'(voice_level(int'(channel_i))));
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_samples.size() == 0) begin
          flag("sample with none outstanding", 0, int'(sample_i));
        end else begin
          want = owed_samples.pop_front();
          if (sample_i !== want) flag("sample mismatch", int'(want), int'(sample_i));
          checked_o++;
        end
      end
    end
    pending_o = owed_samples.size();
  end

endmodule

// ===== tb/programmable_sound_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// programmable_sound_generator_core_tb
// Drives latch/data writes, chip ticks and sample requests into the sound
// generator: a short directed run, then random phases with several register
// settings and changing backpressure. A checker beside the block predicts
// and compares every sample.
// ----------------------------------------------------------------------------
module programmable_sound_generator_core_tb;
  import psg_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int CYCLE_LIMIT  = 150000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              operation;
  logic [7:0]              data_byte;
  logic [1:0]              channel;
  logic                    debug_view;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [15:0]      sample;

  int errors;
  int pending;
  int checked;
  int items_sent = 0;
  int settings   = 0;
  int cycles     = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  programmable_sound_generator_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .data_byte_i  (data_byte),
    .channel_i    (channel),
    .debug_view_i (debug_view),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_o     (sample)
  );

  psg_sample_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .data_byte_i  (data_byte),
    .channel_i    (channel),
    .debug_view_i (debug_view),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .sample_i     (sample),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, pending);
      $display("programmable_sound_generator_core regression: fail");
      $finish;
    end
  end

  // Sample side backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // One item transfer, with random gaps ahead of it; starts and ends at negedge
  task automatic send_item(input op_e op, input logic [7:0] b, input logic [1:0] ch,
                           input logic dbg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    data_byte  <= b;
    channel    <= ch;
    debug_view <= dbg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Both registers in back-to-back cycles while the block is idle
  task automatic set_config(input logic master, input logic [3:0] enables);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MASTER_ENABLE;
    cfg_data  <= {3'b000, master};
    @(negedge clk);
    cfg_index <= CFG_CHANNEL_ENABLE;
    cfg_data  <= enables;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // Wait until every owed sample is back, then let writes and ticks settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_random();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    b    = 8'($urandom_range(255));
    if (pick < 30) begin
      // half raw bytes, half well-formed latch or data bytes with short periods
      if ($urandom_range(1)) begin
        if ($urandom_range(1)) b = {1'b1, 2'($urandom_range(3)), 1'($urandom_range(1)),
                                    4'($urandom_range(15))};
        else                   b = {1'b0, 7'($urandom_range(3))};
      end
      send_item(OP_WRITE, b, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end else if (pick < 65) begin
      send_item(OP_TICK, b, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end else if (pick < 85) begin
      send_item(OP_MIX, b, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end else begin
      send_item(OP_CHAN, b, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic       master;
    logic [3:0] enables;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    operation  = OP_WRITE;
    data_byte  = '0;
    channel    = '0;
    debug_view = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    tx_idle_pct = 23;
    rx_idle_pct = 58;

    // Directed: silent reset state, every byte form, short periods, zero noise reload
    send_item(OP_MIX,   8'h00, 2'd0, 1'b0);
    send_item(OP_WRITE, 8'hFF, 2'd0, 1'b0);   // noise volume 15
    send_item(OP_WRITE, 8'h90, 2'd0, 1'b0);   // tone 0 loudest
    send_item(OP_WRITE, 8'hB7, 2'd0, 1'b0);
    send_item(OP_WRITE, 8'hDE, 2'd0, 1'b0);
    send_item(OP_WRITE, 8'hF0, 2'd0, 1'b0);   // noise loudest
    send_item(OP_WRITE, 8'h8F, 2'd0, 1'b0);   // tone 0 period low nibble
    send_item(OP_WRITE, 8'h3F, 2'd0, 1'b0);   // data form: period 0x3FF
    send_item(OP_WRITE, 8'hA1, 2'd0, 1'b0);
    send_item(OP_WRITE, 8'h00, 2'd0, 1'b0);   // tone 1 period 1
    send_item(OP_WRITE, 8'hC0, 2'd0, 1'b0);   // tone 2 period 0
    send_item(OP_WRITE, 8'hE7, 2'd0, 1'b0);   // white noise following tone 2
    send_item(OP_TICK,  8'h00, 2'd0, 1'b0);
    send_item(OP_TICK,  8'hFF, 2'd3, 1'b1);
    send_item(OP_CHAN,  8'h00, 2'd3, 1'b1);
    send_item(OP_MIX,   8'h00, 2'd0, 1'b1);
    send_item(OP_WRITE, 8'hD0, 2'd0, 1'b0);   // latch tone 2 volume
    send_item(OP_WRITE, 8'h7A, 2'd0, 1'b0);   // data form volume write
    send_item(OP_WRITE, 8'hE0, 2'd0, 1'b0);   // periodic noise, fixed rate
    send_item(OP_WRITE, 8'h06, 2'd0, 1'b0);   // data form noise control
    send_item(OP_TICK,  8'h00, 2'd0, 1'b0);
    send_item(OP_CHAN,  8'h00, 2'd0, 1'b0);
    send_item(OP_CHAN,  8'h00, 2'd1, 1'b0);
    send_item(OP_CHAN,  8'h00, 2'd2, 1'b0);
    send_item(OP_MIX,   8'hFF, 2'd3, 1'b0);
    drain();

    // Random phases, register setting changed while idle between them
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 23;
        rx_idle_pct = 58;
      end else if (ph < 4) begin
        tx_idle_pct = 58;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        0:       begin master = 1'b0; enables = 4'hF; end
        1:       begin master = 1'b1; enables = 4'h0; end
        3:       begin master = 1'b0; enables = 4'($urandom_range(15)); end
        4:       begin master = 1'b1; enables = 4'hF; end
        default: begin master = 1'($urandom_range(1)); enables = 4'($urandom_range(15)); end
      endcase
      set_config(master, enables);
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    repeat (8) @(negedge clk);
    $display("ran %0d items over %0d register settings and three backpressure mixes,",
             items_sent, settings);
    $display("%0d samples compared, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("programmable_sound_generator_core regression: pass");
    end else begin
      $display("programmable_sound_generator_core regression: fail");
    end
    $finish;
  end

endmodule
